@@ sv/gnz_pkg.sv @@
// ----------------------------------------------------------------------------
// gnz_pkg: shared types, constants and functions of the gradient noise block
// Fixed-point formats, function codes, gradient selection and the
// interpolation step used by the pipeline stages.
// ----------------------------------------------------------------------------
package gnz_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int OUT_FRAC_BITS   = 13;
  localparam int TABLE_SIZE      = 256;
  localparam int IDX_W           = $clog2(TABLE_SIZE);

  // Only the low eight integer bits and the fraction of a coordinate matter.
  localparam int SUM_W = COORD_FRAC_BITS + 8;
  localparam int FRAC_SHR = (COORD_FRAC_BITS >= 16) ? COORD_FRAC_BITS - 16 : 0;
  localparam int FRAC_SHL = (COORD_FRAC_BITS < 16) ? 16 - COORD_FRAC_BITS : 0;

  localparam longint unsigned SALT2X = ((64'd1317 << COORD_FRAC_BITS) + 64'd5) / 64'd10;
  localparam longint unsigned SALT2Z = ((64'd713 << COORD_FRAC_BITS) + 64'd5) / 64'd10;
  localparam longint unsigned SALT3X = ((64'd571 << COORD_FRAC_BITS) + 64'd5) / 64'd10;

  localparam int SCALE2D = 45875;

  localparam int OUT_SHR = (OUT_FRAC_BITS <= 16) ? 16 - OUT_FRAC_BITS : 0;
  localparam int OUT_SHL = (OUT_FRAC_BITS > 16) ? OUT_FRAC_BITS - 16 : 0;

  // Register stages, the last one being the output register.
  localparam int NSTG = 10;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_NOISE2 = 2'd1,
    FUNC_NOISE3 = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef logic [IDX_W-1:0]   hash_t;
  typedef logic [15:0]        frac_t;
  typedef logic [16:0]        fade_t;
  typedef logic signed [17:0] dist_t;
  typedef logic signed [18:0] val_t;

  localparam dist_t ONE_D = 18'sd65536;

  typedef struct packed {
    logic [NSTG:1] en;
    logic [3:1]    wr;
  } pipe_ctl_t;

  function automatic val_t grad2(input hash_t h, input dist_t x, input dist_t y);
    val_t xe;
    val_t ye;
    val_t g;
    xe = val_t'(x);
    ye = val_t'(y);
    case (h[2:0])
      3'd0:    g = xe + ye;
      3'd1:    g = ye - xe;
      3'd2:    g = xe - ye;
      3'd3:    g = -xe - ye;
      3'd4:    g = xe;
      3'd5:    g = -xe;
      3'd6:    g = ye;
      default: g = -ye;
    endcase
    return g;
  endfunction

  function automatic val_t grad3(input hash_t h, input dist_t x, input dist_t y,
                                 input dist_t z);
    logic [3:0] k;
    val_t u;
    val_t v;
    k = h[3:0];
    u = (k < 4'd8) ? val_t'(x) : val_t'(y);
    if (k < 4'd4) begin
      v = val_t'(y);
    end else if (k == 4'd12 || k == 4'd14) begin
      v = val_t'(x);
    end else begin
      v = val_t'(z);
    end
    return (k[0] ? -u : u) + (k[1] ? -v : v);
  endfunction

  function automatic val_t lerp(input val_t a, input val_t b, input fade_t t);
    logic signed [19:0] d;
    logic signed [37:0] p;
    d = 20'(b) - 20'(a);
    p = d * $signed({1'b0, t});
    return val_t'(p >>> 16) + a;
  endfunction

endpackage

@@ sv/gnz_if.sv @@
// ----------------------------------------------------------------------------
// gnz_if: item channels of the gradient noise block
// Input channel with function code, coordinates, salt and table load
// fields, and result channel with the noise value and the load flag.
// ----------------------------------------------------------------------------
interface gnz_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;
  logic [7:0]         salt;
  logic [7:0]         table_index;
  logic [7:0]         table_value;

  modport source (output valid, func, coord_x, coord_y, coord_z, salt, table_index,
                  table_value, input ready);
  modport sink (input valid, func, coord_x, coord_y, coord_z, salt, table_index,
                table_value, output ready);
endinterface

interface gnz_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] noise_value;
  logic               was_load;

  modport source (output valid, noise_value, was_load, input ready);
  modport sink (input valid, noise_value, was_load, output ready);
endinterface

@@ sv/gnz_perm_ram.sv @@
// ----------------------------------------------------------------------------
// gnz_perm_ram: one copy of the permutation table
// One write port and two registered read ports.
// ----------------------------------------------------------------------------
module gnz_perm_ram (
  input  logic          clk,
  input  logic          we,
  input  gnz_pkg::hash_t waddr,
  input  gnz_pkg::hash_t wdata,
  input  logic          re,
  input  gnz_pkg::hash_t raddr_a,
  input  gnz_pkg::hash_t raddr_b,
  output gnz_pkg::hash_t rdata_a,
  output gnz_pkg::hash_t rdata_b
);
  import gnz_pkg::*;

  hash_t mem [TABLE_SIZE];
  hash_t rdata_a_r;
  hash_t rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

@@ sv/gnz_hash.sv @@
// ----------------------------------------------------------------------------
// gnz_hash: three levels of permutation lookups
// Each level reads its own copies of the table, and a load item writes
// each copy as it passes that level, so lookups stay in item order.
// ----------------------------------------------------------------------------
module gnz_hash (
  input  logic               clk,
  input  gnz_pkg::pipe_ctl_t ctl,
  input  gnz_pkg::hash_t     cx_i,
  input  gnz_pkg::hash_t     cy_i,
  input  gnz_pkg::hash_t     cz_i,
  input  gnz_pkg::hash_t     idx_i,
  input  gnz_pkg::hash_t     val_i,
  input  gnz_pkg::func_t     func_s4,
  output gnz_pkg::hash_t     corner_o [8]
);
  import gnz_pkg::*;

  hash_t cy2_r, cz2_r, cz3_r;
  hash_t idx2_r, val2_r, idx3_r, val3_r;
  hash_t h2d_r [4];

  hash_t l1a, l1b;
  hash_t l2aa, l2ab, l2ba, l2bb;
  hash_t a2, b2;
  hash_t aa3, ab3, ba3, bb3;
  hash_t l3 [8];

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      cy2_r  <= cy_i;
      cz2_r  <= cz_i;
      idx2_r <= idx_i;
      val2_r <= val_i;
    end
    if (ctl.en[3]) begin
      cz3_r  <= cz2_r;
      idx3_r <= idx2_r;
      val3_r <= val2_r;
    end
    if (ctl.en[4]) begin
      h2d_r[0] <= l2aa;
      h2d_r[1] <= l2ba;
      h2d_r[2] <= l2ab;
      h2d_r[3] <= l2bb;
    end
  end

  gnz_perm_ram u_ram0 (
    .clk(clk), .we(ctl.wr[1]), .waddr(idx_i), .wdata(val_i), .re(ctl.en[2]),
    .raddr_a(cx_i), .raddr_b(cx_i + hash_t'(1)), .rdata_a(l1a), .rdata_b(l1b)
  );

  assign a2 = l1a + cy2_r;
  assign b2 = l1b + cy2_r;

  gnz_perm_ram u_ram1 (
    .clk(clk), .we(ctl.wr[2]), .waddr(idx2_r), .wdata(val2_r), .re(ctl.en[3]),
    .raddr_a(a2), .raddr_b(a2 + hash_t'(1)), .rdata_a(l2aa), .rdata_b(l2ab)
  );

  gnz_perm_ram u_ram2 (
    .clk(clk), .we(ctl.wr[2]), .waddr(idx2_r), .wdata(val2_r), .re(ctl.en[3]),
    .raddr_a(b2), .raddr_b(b2 + hash_t'(1)), .rdata_a(l2ba), .rdata_b(l2bb)
  );

  assign aa3 = l2aa + cz3_r;
  assign ab3 = l2ab + cz3_r;
  assign ba3 = l2ba + cz3_r;
  assign bb3 = l2bb + cz3_r;

  gnz_perm_ram u_ram3 (
    .clk(clk), .we(ctl.wr[3]), .waddr(idx3_r), .wdata(val3_r), .re(ctl.en[4]),
    .raddr_a(aa3), .raddr_b(aa3 + hash_t'(1)), .rdata_a(l3[0]), .rdata_b(l3[4])
  );

  gnz_perm_ram u_ram4 (
    .clk(clk), .we(ctl.wr[3]), .waddr(idx3_r), .wdata(val3_r), .re(ctl.en[4]),
    .raddr_a(ab3), .raddr_b(ab3 + hash_t'(1)), .rdata_a(l3[2]), .rdata_b(l3[6])
  );

  gnz_perm_ram u_ram5 (
    .clk(clk), .we(ctl.wr[3]), .waddr(idx3_r), .wdata(val3_r), .re(ctl.en[4]),
    .raddr_a(ba3), .raddr_b(ba3 + hash_t'(1)), .rdata_a(l3[1]), .rdata_b(l3[5])
  );

  gnz_perm_ram u_ram6 (
    .clk(clk), .we(ctl.wr[3]), .waddr(idx3_r), .wdata(val3_r), .re(ctl.en[4]),
    .raddr_a(bb3), .raddr_b(bb3 + hash_t'(1)), .rdata_a(l3[3]), .rdata_b(l3[7])
  );

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      if (func_s4 == FUNC_NOISE2 && k < 4) begin
        corner_o[k] = h2d_r[k];
      end else begin
        corner_o[k] = l3[k];
      end
    end
  end

endmodule

@@ sv/gnz_fade.sv @@
// ----------------------------------------------------------------------------
// gnz_fade: quintic fade curve for three fractions
// One multiplication per stage, five stages from fraction to fade value.
// ----------------------------------------------------------------------------
module gnz_fade (
  input  logic               clk,
  input  gnz_pkg::pipe_ctl_t ctl,
  input  gnz_pkg::frac_t     frac_i  [3],
  output gnz_pkg::frac_t     frac_s4 [3],
  output gnz_pkg::fade_t     fade_s6 [3]
);
  import gnz_pkg::*;

  frac_t       t2_r [3];
  frac_t       t3_r [3];
  frac_t       t4_r [3];
  frac_t       t5_r [3];
  logic [31:0] tt2_r [3];
  logic [36:0] p3_r [3];
  logic [36:0] r4_r [3];
  logic [36:0] r5_r [3];
  fade_t       fade6_r [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (ctl.en[2]) begin
        t2_r[i]  <= frac_i[i];
        tt2_r[i] <= 32'(frac_i[i]) * 32'(frac_i[i]);
      end
      if (ctl.en[3]) begin
        t3_r[i] <= t2_r[i];
        p3_r[i] <= 37'(tt2_r[i]) * 37'd6 + (37'd10 << 32)
                   - ((37'(t2_r[i]) * 37'd15) << 16);
      end
      if (ctl.en[4]) begin
        t4_r[i] <= t3_r[i];
        r4_r[i] <= 37'((53'(p3_r[i]) * 53'(t3_r[i])) >> 16);
      end
      if (ctl.en[5]) begin
        t5_r[i] <= t4_r[i];
        r5_r[i] <= 37'((53'(r4_r[i]) * 53'(t4_r[i])) >> 16);
      end
      if (ctl.en[6]) begin
        fade6_r[i] <= 17'((53'(r5_r[i]) * 53'(t5_r[i])) >> 32);
      end
    end
  end

  assign frac_s4 = t4_r;
  assign fade_s6 = fade6_r;

endmodule

@@ sv/gnz_blend.sv @@
// ----------------------------------------------------------------------------
// gnz_blend: gradients, interpolation and output conversion
// Corner gradients, the lerps along x, y and z (or the 2D scale), and the
// floor shift with saturation into the output register.
// ----------------------------------------------------------------------------
module gnz_blend (
  input  logic               clk,
  input  gnz_pkg::pipe_ctl_t ctl,
  input  gnz_pkg::hash_t     corner_i [8],
  input  gnz_pkg::frac_t     frac_s4  [3],
  input  gnz_pkg::fade_t     fade_s6  [3],
  input  gnz_pkg::func_t     func_s4,
  input  gnz_pkg::func_t     func_s8,
  input  gnz_pkg::func_t     func_s9,
  output logic signed [15:0] noise_o,
  output logic               was_load_o
);
  import gnz_pkg::*;

  val_t  g_nxt [8];
  val_t  g5_r [8];
  val_t  g6_r [8];
  val_t  l7_r [4];
  val_t  m8_r [2];
  val_t  n9_r;
  fade_t fv7_r, fw7_r, fw8_r;
  logic signed [15:0] noise10_r;
  logic               load10_r;

  dist_t d0 [3];
  dist_t d1 [3];

  logic signed [35:0] scaled;
  val_t               n_nxt;
  logic signed [23:0] shifted;
  logic signed [15:0] sat;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d0[i] = dist_t'({2'b00, frac_s4[i]});
      d1[i] = d0[i] - ONE_D;
    end
    for (int k = 0; k < 8; k++) begin
      if (func_s4 == FUNC_NOISE2) begin
        g_nxt[k] = grad2(corner_i[k], k[0] ? d1[0] : d0[0], k[1] ? d1[1] : d0[1]);
      end else begin
        g_nxt[k] = grad3(corner_i[k], k[0] ? d1[0] : d0[0], k[1] ? d1[1] : d0[1],
                         k[2] ? d1[2] : d0[2]);
      end
    end
  end

  always_comb begin
    scaled = m8_r[0] * 36'sd45875;
    if (func_s8 == FUNC_NOISE2) begin
      n_nxt = val_t'(scaled >>> 16);
    end else begin
      n_nxt = lerp(m8_r[0], m8_r[1], fw8_r);
    end
  end

  always_comb begin
    if (OUT_FRAC_BITS <= 16) begin
      shifted = 24'(n9_r) >>> OUT_SHR;
    end else begin
      shifted = 24'(n9_r) <<< OUT_SHL;
    end
    if (shifted > 24'sd32767) begin
      sat = 16'sh7fff;
    end else if (shifted < -24'sd32768) begin
      sat = -16'sh8000;
    end else begin
      sat = 16'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[5]) begin
      g5_r <= g_nxt;
    end
    if (ctl.en[6]) begin
      g6_r <= g5_r;
    end
    if (ctl.en[7]) begin
      for (int j = 0; j < 4; j++) begin
        l7_r[j] <= lerp(g6_r[2*j], g6_r[2*j+1], fade_s6[0]);
      end
      fv7_r <= fade_s6[1];
      fw7_r <= fade_s6[2];
    end
    if (ctl.en[8]) begin
      m8_r[0] <= lerp(l7_r[0], l7_r[1], fv7_r);
      m8_r[1] <= lerp(l7_r[2], l7_r[3], fv7_r);
      fw8_r   <= fw7_r;
    end
    if (ctl.en[9]) begin
      n9_r <= n_nxt;
    end
    if (ctl.en[10]) begin
      noise10_r <= (func_s9 == FUNC_NOISE2 || func_s9 == FUNC_NOISE3) ? sat : '0;
      load10_r  <= (func_s9 == FUNC_LOAD);
    end
  end

  assign noise_o    = noise10_r;
  assign was_load_o = load10_r;

endmodule

@@ sv/gradient_noise_2d_3d.sv @@
// ----------------------------------------------------------------------------
// gradient_noise_2d_3d: improved gradient noise in 2D and 3D, fixed point
// Top level with the coordinate split stage and the pipeline control.
// ----------------------------------------------------------------------------
// The block takes one item per cycle while the output is not stalled and
// returns one result per item, in order. The depth is set by the three
// chained permutation lookups (each level has its own table copies with a
// registered read) and the four multiplications of the fade curve. Each
// stage holds only when it is full and the one after it holds, so a stall
// fills bubbles before it stops the input. Load items write the table
// as they pass each lookup level, so a noise item after a load sees it. The
// table has no reset and must be loaded before noise items are sent.
module gradient_noise_2d_3d (
  input  logic clk,
  input  logic rst_n,
  gnz_in_if.sink    in_ch,
  gnz_out_if.source out_ch
);
  import gnz_pkg::*;

  pipe_ctl_t ctl;
  logic [NSTG:0] v_all;
  logic [NSTG:1] v_r, v_nxt;
  func_t func_r [1:NSTG];

  hash_t cx1_r, cy1_r, cz1_r, idx1_r, val1_r;
  frac_t f1_r [3];

  func_t            func_in;
  logic [SUM_W-1:0] salt_w, kx, offx, offz, sx, sy, sz;

  hash_t corner [8];
  frac_t frac4 [3];
  fade_t fade6 [3];

  function automatic frac_t frac_of(input logic [SUM_W-1:0] s);
    if (COORD_FRAC_BITS >= 16) begin
      return frac_t'(s >> FRAC_SHR);
    end
    return frac_t'(s << FRAC_SHL);
  endfunction

  always_comb begin
    func_in = func_t'(in_ch.func);
    salt_w  = SUM_W'(in_ch.salt);
    kx      = (func_in == FUNC_NOISE2) ? SUM_W'(SALT2X) : SUM_W'(SALT3X);
    offx    = SUM_W'(salt_w * kx);
    offz    = SUM_W'(salt_w * SUM_W'(SALT2Z));
    sx      = SUM_W'(in_ch.coord_x) + offx;
    sy      = (func_in == FUNC_NOISE2) ? SUM_W'(in_ch.coord_z) + offz
                                       : SUM_W'(in_ch.coord_y);
    sz      = SUM_W'(in_ch.coord_z);
  end

  always_comb begin
    v_all = {v_r, in_ch.valid};
    ctl.en[NSTG] = !v_r[NSTG] || out_ch.ready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      ctl.en[k] = !v_r[k] || ctl.en[k+1];
    end
    for (int k = 1; k <= NSTG; k++) begin
      v_nxt[k] = ctl.en[k] ? v_all[k-1] : v_r[k];
    end
    for (int k = 1; k <= 3; k++) begin
      ctl.wr[k] = v_r[k] && ctl.en[k+1] && (func_r[k] == FUNC_LOAD);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      func_r[1] <= func_in;
      cx1_r     <= sx[SUM_W-1 -: IDX_W];
      cy1_r     <= sy[SUM_W-1 -: IDX_W];
      cz1_r     <= sz[SUM_W-1 -: IDX_W];
      f1_r[0]   <= frac_of(sx);
      f1_r[1]   <= frac_of(sy);
      f1_r[2]   <= frac_of(sz);
      idx1_r    <= in_ch.table_index;
      val1_r    <= in_ch.table_value;
    end
    for (int k = 2; k <= NSTG; k++) begin
      if (ctl.en[k]) begin
        func_r[k] <= func_r[k-1];
      end
    end
  end

  gnz_hash u_hash (
    .clk(clk), .ctl(ctl), .cx_i(cx1_r), .cy_i(cy1_r), .cz_i(cz1_r),
    .idx_i(idx1_r), .val_i(val1_r), .func_s4(func_r[4]), .corner_o(corner)
  );

  gnz_fade u_fade (
    .clk(clk), .ctl(ctl), .frac_i(f1_r), .frac_s4(frac4), .fade_s6(fade6)
  );

  gnz_blend u_blend (
    .clk(clk), .ctl(ctl), .corner_i(corner), .frac_s4(frac4), .fade_s6(fade6),
    .func_s4(func_r[4]), .func_s8(func_r[8]), .func_s9(func_r[9]),
    .noise_o(out_ch.noise_value), .was_load_o(out_ch.was_load)
  );

  assign in_ch.ready  = ctl.en[1];
  assign out_ch.valid = v_r[NSTG];

`ifndef NO_ASSERTIONS
  // A load acknowledgment carries no noise.
  a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.was_load |-> out_ch.noise_value == 16'sd0)
    else $error("load result with nonzero noise value");

  // The input is held off only when every stage holds an item.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> &v_r)
    else $error("input stalled with an empty stage");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> v_r == '0)
    else $error("pipeline not empty after reset");
`endif

endmodule

@@ dv/gnz_tb_if.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gnz_tb_if: testbench constants of the gradient noise bench
// The block's own interfaces are used; this file holds the package with
// the watchdog limit shared by the testbench.
// ----------------------------------------------------------------------------
package gnz_tb_pkg;
  localparam int WATCHDOG_CYCLES = 20000;
endpackage

@@ dv/gradient_noise_2d_3d_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gradient_noise_2d_3d_tb: self-checking bench for the gradient noise block
// Loads the permutation table, then sends directed and random 2D, 3D, load
// and unused-code items; a predictor works out each noise value and a
// checker compares the results in order, with random stalls on both sides.
// ----------------------------------------------------------------------------
module gradient_noise_2d_3d_tb;
  import gnz_pkg::*;
  import gnz_tb_pkg::*;

  typedef struct packed {
    logic signed [15:0] noise_value;
    logic               was_load;
  } noise_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  gnz_in_if  in_ch ();
  gnz_out_if out_ch ();

  gradient_noise_2d_3d uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  logic [7:0]  perm [256];
  noise_res_t  pending_noise [$];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_off = 0;
  int          errors = 0;
  int          n_items = 0;
  int          n_results = 0;
  int          quiet_cycles = 0;

  function automatic longint asr64(longint v, int s);
    return v >>> s;
  endfunction

  function automatic void split_coord(logic [31:0] raw, longint unsigned off,
                                      output int cell_idx, output longint frac);
    longint unsigned u;
    u = longint'($signed(raw)) + off;
    cell_idx = int'((u >> COORD_FRAC_BITS) & 64'd255);
    frac = longint'(u & ((64'd1 << COORD_FRAC_BITS) - 1));
    if (COORD_FRAC_BITS >= 16) frac = frac >> (COORD_FRAC_BITS - 16);
    else frac = frac << (16 - COORD_FRAC_BITS);
  endfunction

  function automatic longint fade_q16(longint t);
    longint unsigned tu, p, r;
    tu = t;
    p = 64'd6 * tu * tu + (64'd10 << 32) - ((64'd15 * tu) << 16);
    r = (p * tu) >> 16;
    r = (r * tu) >> 16;
    return longint'((r * tu) >> 32);
  endfunction

  function automatic longint blend(longint a, longint b, longint t);
    return a + asr64((b - a) * t, 16);
  endfunction

  function automatic longint dot2(int h, longint x, longint y);
    case (h & 7)
      0: return x + y;
      1: return -x + y;
      2: return x - y;
      3: return -x - y;
      4: return x;
      5: return -x;
      6: return y;
      default: return -y;
    endcase
  endfunction

  function automatic longint dot3(int h, longint x, longint y, longint z);
    int k;
    longint u, v;
    k = h & 15;
    u = (k < 8) ? x : y;
    v = (k < 4) ? y : ((k == 12 || k == 14) ? x : z);
    return ((k & 1) ? -u : u) + ((k & 2) ? -v : v);
  endfunction

  function automatic int lk(int i);
    return perm[i & 255];
  endfunction

  function automatic logic signed [15:0] saturate_out(longint r);
    if (OUT_FRAC_BITS <= 16) r = asr64(r, 16 - OUT_FRAC_BITS);
    else r = r * (longint'(1) << (OUT_FRAC_BITS - 16));
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic noise_res_t predict_noise(func_t f, logic [31:0] x, logic [31:0] y,
                                               logic [31:0] z, logic [7:0] s,
                                               logic [7:0] idx, logic [7:0] val);
    noise_res_t res;
    int cx, cy, cz, a, b, aa, ab, ba, bb, pa, pb;
    longint fx, fy, fz, u, v, w, lo, hi, r;
    res = '0;
    case (f)
      FUNC_LOAD: begin
        perm[idx] = val;
        res.was_load = 1'b1;
      end
      FUNC_NOISE2: begin
        split_coord(x, longint'(s) * SALT2X, cx, fx);
        split_coord(z, longint'(s) * SALT2Z, cz, fz);
        u = fade_q16(fx);
        v = fade_q16(fz);
        pa = lk(cx);
        pb = lk(cx + 1);
        r = blend(blend(dot2(lk(pa + cz), fx, fz), dot2(lk(pb + cz), fx - 65536, fz), u),
                  blend(dot2(lk(pa + cz + 1), fx, fz - 65536),
                        dot2(lk(pb + cz + 1), fx - 65536, fz - 65536), u), v);
        res.noise_value = saturate_out(asr64(r * SCALE2D, 16));
      end
      FUNC_NOISE3: begin
        split_coord(x, longint'(s) * SALT3X, cx, fx);
        split_coord(y, 0, cy, fy);
        split_coord(z, 0, cz, fz);
        u = fade_q16(fx);
        v = fade_q16(fy);
        w = fade_q16(fz);
        a = lk(cx) + cy;
        b = lk(cx + 1) + cy;
        aa = lk(a) + cz;
        ab = lk(a + 1) + cz;
        ba = lk(b) + cz;
        bb = lk(b + 1) + cz;
        lo = blend(blend(dot3(lk(aa), fx, fy, fz), dot3(lk(ba), fx - 65536, fy, fz), u),
                   blend(dot3(lk(ab), fx, fy - 65536, fz),
                         dot3(lk(bb), fx - 65536, fy - 65536, fz), u), v);
        hi = blend(blend(dot3(lk(aa + 1), fx, fy, fz - 65536),
                         dot3(lk(ba + 1), fx - 65536, fy, fz - 65536), u),
                   blend(dot3(lk(ab + 1), fx, fy - 65536, fz - 65536),
                         dot3(lk(bb + 1), fx - 65536, fy - 65536, fz - 65536), u), v);
        res.noise_value = saturate_out(blend(lo, hi, w));
      end
      default: ;
    endcase
    return res;
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_NONE;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    in_ch.coord_z = '0;
    in_ch.salt = '0;
    in_ch.table_index = '0;
    in_ch.table_value = '0;
    out_ch.ready = 1'b0;
  end

  task automatic send_item(func_t f, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [7:0] s, logic [7:0] idx, logic [7:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= f;
    in_ch.coord_x <= x;
    in_ch.coord_y <= y;
    in_ch.coord_z <= z;
    in_ch.salt <= s;
    in_ch.table_index <= idx;
    in_ch.table_value <= val;
    pending_noise.push_back(predict_noise(f, x, y, z, s, idx, val));
    n_items++;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    noise_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (pending_noise.size() == 0) begin
        $error("result with no item outstanding: noise_value %0d was_load %0b",
               out_ch.noise_value, out_ch.was_load);
        errors++;
      end else begin
        want = pending_noise.pop_front();
        if (out_ch.noise_value !== want.noise_value) begin
          $error("noise_value: expected %0d, got %0d", want.noise_value, out_ch.noise_value);
          errors++;
        end
        if (out_ch.was_load !== want.was_load) begin
          $error("was_load: expected %0b, got %0b", want.was_load, out_ch.was_load);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("watchdog: no item moved for %0d cycles", quiet_cycles);
      $display("** gradient_noise_2d_3d: FAILED **");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(65535 * 8)) - 32'sd262144);
      2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return {8'($urandom()), 8'h00, 16'($urandom())} ^
                      {1'($urandom_range(1)), 31'd0};
    endcase
  endfunction

  task automatic test_table_load();
    for (int i = 0; i < 256; i++)
      send_item(FUNC_LOAD, $urandom(), $urandom(), $urandom(), 8'($urandom()), 8'(i),
                8'($urandom()));
  endtask

  task automatic test_directed();
    logic [31:0] ext [4];
    ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
    foreach (ext[i]) begin
      send_item(FUNC_NOISE2, ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4], 8'd0, 8'hFF, 8'hFF);
      send_item(FUNC_NOISE3, ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4], 8'd255, 8'h00, 8'h00);
    end
    send_item(FUNC_NOISE2, 32'h00FF_8000, 32'h0, 32'h00FF_FFFF, 8'd255, 8'h55, 8'hAA);
    send_item(FUNC_NOISE3, 32'h00FF_FFFF, 32'h00FF_0001, 32'hFF00_8000, 8'd1, 8'hAA, 8'h55);
    send_item(FUNC_NOISE3, 32'h0001_0000, 32'h0101_0000, 32'hFF01_0000, 8'd0, 8'd0, 8'd0);
    send_item(FUNC_NONE, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF);
    send_item(FUNC_NONE, 32'h0, 32'h0, 32'h0, 8'h0, 8'h0, 8'h0);
    send_item(FUNC_LOAD, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 8'hFF, 8'd0, 8'hFF);
    send_item(FUNC_LOAD, 32'h0, 32'hFFFF_FFFF, 32'h0, 8'h0, 8'd255, 8'h00);
    send_item(FUNC_NOISE2, 32'h0000_8000, 32'h0, 32'h0000_8000, 8'd0, 8'd0, 8'd0);
    send_item(FUNC_NOISE3, 32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000, 8'd128, 8'd0, 8'd0);
  endtask

  task automatic test_random(int count);
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(99);
      if (k < 45)
        send_item(FUNC_NOISE2, rand_coord(), $urandom(), rand_coord(), 8'($urandom()),
                  8'($urandom()), 8'($urandom()));
      else if (k < 90)
        send_item(FUNC_NOISE3, rand_coord(), rand_coord(), rand_coord(), 8'($urandom()),
                  8'($urandom()), 8'($urandom()));
      else if (k < 97)
        send_item(FUNC_LOAD, $urandom(), $urandom(), $urandom(), 8'($urandom()),
                  8'($urandom()), 8'($urandom()));
      else
        send_item(FUNC_NONE, $urandom(), $urandom(), $urandom(), 8'($urandom()),
                  8'($urandom()), 8'($urandom()));
    end
  endtask

  task automatic test_back_pressure();
    hold_off = 300;
    send_idle_pct = 0;
    test_random(60);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (pending_noise.size() > 0 && guard < WATCHDOG_CYCLES) begin
      @(posedge clk);
      guard++;
    end
    repeat (4 * NSTG) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle_pct = 38;
    recv_idle_pct = 55;
    test_table_load();
    test_directed();
    test_random(300);
    send_idle_pct = 55;
    recv_idle_pct = 38;
    test_random(300);
    test_back_pressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(380);
    drain();
    if (pending_noise.size() > 0) begin
      $error("%0d expected results never arrived", pending_noise.size());
      errors++;
    end
    $display("Sent %0d items (table loads, 2D and 3D noise, unused code), checked %0d results.",
             n_items, n_results);
    $display("Stalls covered sender-heavy, receiver-heavy, none and one long hold-off.");
    if (errors == 0) begin
      $display("** gradient_noise_2d_3d: PASSED **");
    end else begin
      $display("** gradient_noise_2d_3d: FAILED **");
    end
    $finish;
  end
endmodule

@@ files.f @@
sv/gnz_pkg.sv
sv/gnz_if.sv
sv/gnz_perm_ram.sv
sv/gnz_hash.sv
sv/gnz_fade.sv
sv/gnz_blend.sv
sv/gradient_noise_2d_3d.sv
dv/gnz_tb_if.sv
dv/gradient_noise_2d_3d_tb.sv
